>>> sv/mnil_pkg.sv
// mnil_pkg: constants, word types and the note frequency table for the
// melody note interval look-up block; no dependencies
package mnil_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TIME_BITS   = 24;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int NOTE_W      = 7;
    localparam int FREQ_W      = 18;
    localparam int NOTES       = 128;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]           func;
        logic [TIME_BITS-1:0] start_tick;
        logic [TIME_BITS-1:0] duration;
        logic [NOTE_W-1:0]    note_num;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic [NOTE_W-1:0] target_note;
        logic [FREQ_W-1:0] pitch_freq;
        logic              is_rest;
    } rsp_t;

    // stored event, end time kept with one extra bit so it never wraps
    typedef struct packed {
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS:0]   stop;
        logic [NOTE_W-1:0]    note;
    } event_t;

    typedef logic [FREQ_W-1:0] freq_table_t [NOTES];

    // 2^(r/12) scaled by 10^12
    localparam logic [63:0] SEMITONE_RATIO [12] = '{
        64'd1000000000000, 64'd1059463094359, 64'd1122462048309,
        64'd1189207115003, 64'd1259921049895, 64'd1334839854170,
        64'd1414213562373, 64'd1498307076877, 64'd1587401051968,
        64'd1681792830507, 64'd1781797436281, 64'd1887748625363
    };

    localparam logic [63:0] FREQ_DEN = 64'd64000000000000;

    // round(16 * 440 * 2^((n-69)/12)), built at elaboration
    function automatic freq_table_t build_freq_table();
        freq_table_t t;
        logic [63:0] num;
        int          d;
        for (int n = 0; n < NOTES; n++)
        begin
            d    = n + 3;
            num  = (64'd7040 * SEMITONE_RATIO[d % 12]) << (d / 12);
            t[n] = FREQ_W'((num + FREQ_DEN / 64'd2) / FREQ_DEN);
        end
        return t;
    endfunction

    localparam freq_table_t FREQ_TABLE = build_freq_table();

endpackage

>>> sv/melody_note_interval_lookup.sv
// melody_note_interval_lookup: event table in one synchronous memory with add, clear
// and in-order interval look-up of the note at a phoneme midpoint; depends on mnil_pkg
// add, clear and unused codes give done in the cycle after the start; a look-up reads
// the events in order, one per cycle from the memory, to the first hit or the last, then
// ST_FIN registers the result; busy drops in the done cycle, add and clear every cycle
// while idle; reset clears the event count and control only, the memory is not swept
module melody_note_interval_lookup (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mnil_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output mnil_pkg::rsp_t rsp
);
    import mnil_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               last_reg, last_next;
    logic [TIME_BITS:0] mid_reg, mid_next;
    logic [NOTE_W-1:0]  note_reg, note_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    event_t             event_mem [TABLE_DEPTH];
    event_t             rd_data_reg;
    event_t             wr_data;
    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic               full;
    logic               hit;

    assign full = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign hit  = (mid_reg >= {1'b0, rd_data_reg.start}) && (mid_reg < rd_data_reg.stop);

    assign wr_data.start = cmd.start_tick;
    assign wr_data.stop  = {1'b0, cmd.start_tick} + {1'b0, cmd.duration};
    assign wr_data.note  = cmd.note_num;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        mid_next   = mid_reg;
        note_next  = note_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        mem_we     = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    unique case (cmd.func)
                        FUNC_ADD:
                        begin
                            if (full)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.pitch_freq = FREQ_TABLE[0];
                                rsp_next.is_rest    = 1'b1;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                                idx_next   = ADDR_W'(1);
                                last_next  = (count_reg == COUNT_W'(1));
                                mid_next   = {1'b0, cmd.start_tick}
                                             + {2'b00, cmd.duration[TIME_BITS-1:1]};
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    note_next  = rd_data_reg.note;
                    state_next = ST_FIN;
                end
                else if (last_reg)
                begin
                    note_next  = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_addr   = idx_reg;
                    idx_next  = idx_reg + ADDR_W'(1);
                    last_next = ({1'b0, idx_reg} == count_reg - COUNT_W'(1));
                end
            end
            ST_FIN:
            begin
                done_next            = 1'b1;
                rsp_next.target_note = note_reg;
                rsp_next.pitch_freq  = FREQ_TABLE[note_reg];
                rsp_next.is_rest     = (note_reg == '0);
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // event memory, write at the fill count, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            event_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= event_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
        mid_reg  <= mid_next;
        note_reg <= note_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("event count beyond table depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while still busy");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_ADD && full
        |=> done && rsp.status && $stable(count_reg))
        else $error("add to full table not refused");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> done && !rsp.status)
        else $error("look-up finished without a result word");
`endif

endmodule
